// ===== rtl/core/eis_pkg.sv =====
// eis_pkg: types, constants and the micro-program of the epipolar inlier scorer
// used by eis_ctrl, eis_dp, epipolar_inlier_scorer and eis_checker; no dependencies
package eis_pkg;

  localparam int unsigned MAX_MATCHES_DEF     = 4096;
  localparam int unsigned COORD_FRAC_BITS_DEF = 20;

  localparam int unsigned LIMBS     = 6;
  localparam int unsigned WIDE_W    = LIMBS * 32;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned PC_W      = 6;
  localparam int unsigned REP_W     = 5;

  localparam logic [31:0] CHI_LIMIT = 32'd251724;
  localparam logic [31:0] CHI_BONUS = 32'd785252;

  localparam logic [23:0] FOCAL_RESET = 24'd128000;
  localparam logic [31:0] INV_RESET   = 32'd16777216;

  localparam logic [1:0] CFG_FOCAL_X      = 2'd0;
  localparam logic [1:0] CFG_FOCAL_Y      = 2'd1;
  localparam logic [1:0] CFG_INV_SIGMA_SQ = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // line register slots
  localparam logic [3:0] L_P0 = 4'd0;
  localparam logic [3:0] L_P1 = 4'd1;
  localparam logic [3:0] L_P2 = 4'd2;
  localparam logic [3:0] L_Q0 = 4'd3;
  localparam logic [3:0] L_Q1 = 4'd4;
  localparam logic [3:0] L_D  = 4'd5;

  typedef enum logic [3:0] {
    UOP_NOP, UOP_MAC_CLR, UOP_MAC, UOP_STORE, UOP_WSET, UOP_WMUL, UOP_SAVE_NUM,
    UOP_SAVE_T, UOP_DEN, UOP_SATCHK, UOP_DIV, UOP_CHI, UOP_END
  } uop_e;

  typedef enum logic [2:0] {B_AX, B_AY, B_BX, B_BY, B_ONE} bsel_e;
  typedef enum logic [1:0] {F_LINE, F_INV, F_FX, F_FY} fsel_e;
  typedef enum logic {A_COEF, A_LINE} asrc_e;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} ctrl_state_e;

  typedef struct packed {
    uop_e             op;
    logic [REP_W-1:0] rep;
    asrc_e            asrc;
    logic [3:0]       idx;
    bsel_e            bsel;
    fsel_e            fsel;
  } uword_t;

  typedef struct packed {
    logic   accept;
    logic   first;
    uword_t word;
  } dp_cmd_t;

  typedef struct packed {
    logic eval_cmd;
  } dp_sts_t;

  function automatic uword_t mk(uop_e op, logic [REP_W-1:0] rep, asrc_e asrc,
                                logic [3:0] idx, bsel_e bsel, fsel_e fsel);
    uword_t w;
    w.op   = op;
    w.rep  = rep;
    w.asrc = asrc;
    w.idx  = idx;
    w.bsel = bsel;
    w.fsel = fsel;
    return w;
  endfunction

  function automatic uword_t u_mac(logic clr, asrc_e asrc, logic [3:0] idx, bsel_e bsel);
    return mk(clr ? UOP_MAC_CLR : UOP_MAC, '0, asrc, idx, bsel, F_LINE);
  endfunction

  function automatic uword_t u_one(uop_e op, logic [3:0] idx);
    return mk(op, '0, A_COEF, idx, B_AX, F_LINE);
  endfunction

  function automatic uword_t u_wm(fsel_e fsel, logic [3:0] idx);
    return mk(UOP_WMUL, REP_W'(LIMBS - 1), A_COEF, idx, B_AX, fsel);
  endfunction

  function automatic uword_t ucode(logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      6'd0:  w = u_mac(1'b1, A_COEF, 4'd0, B_AX);
      6'd1:  w = u_mac(1'b0, A_COEF, 4'd1, B_AY);
      6'd2:  w = u_mac(1'b0, A_COEF, 4'd2, B_ONE);
      6'd3:  w = u_one(UOP_STORE, L_P0);
      6'd4:  w = u_mac(1'b1, A_COEF, 4'd3, B_AX);
      6'd5:  w = u_mac(1'b0, A_COEF, 4'd4, B_AY);
      6'd6:  w = u_mac(1'b0, A_COEF, 4'd5, B_ONE);
      6'd7:  w = u_one(UOP_STORE, L_P1);
      6'd8:  w = u_mac(1'b1, A_COEF, 4'd6, B_AX);
      6'd9:  w = u_mac(1'b0, A_COEF, 4'd7, B_AY);
      6'd10: w = u_mac(1'b0, A_COEF, 4'd8, B_ONE);
      6'd11: w = u_one(UOP_STORE, L_P2);
      6'd12: w = u_mac(1'b1, A_COEF, 4'd0, B_BX);
      6'd13: w = u_mac(1'b0, A_COEF, 4'd3, B_BY);
      6'd14: w = u_mac(1'b0, A_COEF, 4'd6, B_ONE);
      6'd15: w = u_one(UOP_STORE, L_Q0);
      6'd16: w = u_mac(1'b1, A_COEF, 4'd1, B_BX);
      6'd17: w = u_mac(1'b0, A_COEF, 4'd4, B_BY);
      6'd18: w = u_mac(1'b0, A_COEF, 4'd7, B_ONE);
      6'd19: w = u_one(UOP_STORE, L_Q1);
      6'd20: w = u_mac(1'b1, A_LINE, L_P0, B_BX);
      6'd21: w = u_mac(1'b0, A_LINE, L_P1, B_BY);
      6'd22: w = u_mac(1'b0, A_LINE, L_P2, B_ONE);
      6'd23: w = u_one(UOP_STORE, L_D);
      // numerator d^2 * inv * fx^2 * fy^2
      6'd24: w = u_one(UOP_WSET, L_D);
      6'd25: w = u_wm(F_LINE, L_D);
      6'd26: w = u_wm(F_INV, '0);
      6'd27: w = u_wm(F_FX, '0);
      6'd28: w = u_wm(F_FX, '0);
      6'd29: w = u_wm(F_FY, '0);
      6'd30: w = u_wm(F_FY, '0);
      6'd31: w = u_one(UOP_SAVE_NUM, '0);
      // first image
      6'd32: w = u_one(UOP_WSET, L_Q0);
      6'd33: w = u_wm(F_LINE, L_Q0);
      6'd34: w = u_wm(F_FY, '0);
      6'd35: w = u_wm(F_FY, '0);
      6'd36: w = u_one(UOP_SAVE_T, '0);
      6'd37: w = u_one(UOP_WSET, L_Q1);
      6'd38: w = u_wm(F_LINE, L_Q1);
      6'd39: w = u_wm(F_FX, '0);
      6'd40: w = u_wm(F_FX, '0);
      6'd41: w = u_one(UOP_DEN, '0);
      6'd42: w = u_one(UOP_SATCHK, '0);
      6'd43: w = mk(UOP_DIV, REP_W'(DIV_STEPS - 1), A_COEF, '0, B_AX, F_LINE);
      6'd44: w = u_one(UOP_CHI, 4'd0);
      // second image
      6'd45: w = u_one(UOP_WSET, L_P0);
      6'd46: w = u_wm(F_LINE, L_P0);
      6'd47: w = u_wm(F_FY, '0);
      6'd48: w = u_wm(F_FY, '0);
      6'd49: w = u_one(UOP_SAVE_T, '0);
      6'd50: w = u_one(UOP_WSET, L_P1);
      6'd51: w = u_wm(F_LINE, L_P1);
      6'd52: w = u_wm(F_FX, '0);
      6'd53: w = u_wm(F_FX, '0);
      6'd54: w = u_one(UOP_DEN, '0);
      6'd55: w = u_one(UOP_SATCHK, '0);
      6'd56: w = mk(UOP_DIV, REP_W'(DIV_STEPS - 1), A_COEF, '0, B_AX, F_LINE);
      6'd57: w = u_one(UOP_CHI, 4'd1);
      default: w = u_one(UOP_END, '0);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/eis_ctrl.sv =====
// eis_ctrl: handshake state machine and micro-program sequencer
// depends on eis_pkg
module eis_ctrl import eis_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  output logic    s_ready_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [PC_W-1:0]  pc_q, pc_d;
  logic [REP_W-1:0] rep_q, rep_d;
  uword_t           word;

  assign word = ucode(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    rep_d   = rep_q;
    unique case (state_q)
      ST_IDLE: begin
        pc_d  = '0;
        rep_d = '0;
        if (s_valid_i) begin
          state_d = (sts_i.eval_cmd == CMD_EVAL) ? ST_RUN : ST_OUT;
        end
      end
      ST_RUN: begin
        if (word.op == UOP_END) begin
          state_d = ST_OUT;
        end else if (rep_q == word.rep) begin
          pc_d  = pc_q + 1'b1;
          rep_d = '0;
        end else begin
          rep_d = rep_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (m_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o       = (state_q == ST_IDLE);
    m_valid_o       = (state_q == ST_OUT);
    cmd_o.accept    = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.first     = (rep_q == '0);
    cmd_o.word      = word;
    if (state_q != ST_RUN) begin
      cmd_o.word.op = UOP_NOP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      rep_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      rep_q   <= rep_d;
    end
  end

endmodule

// ===== rtl/core/eis_dp.sv =====
// eis_dp: coefficient store, line mac, limb multiplier, bit-serial divider, totals
// depends on eis_pkg; driven by eis_ctrl
module eis_dp import eis_pkg::*; #(
  parameter int unsigned MAX_MATCHES     = MAX_MATCHES_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dp_cmd_t      cmd_i,
  output dp_sts_t      sts_o,
  input  logic [1:0]   in_user_i,
  input  logic [143:0] in_data_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  output logic [109:0] out_data_o
);

  localparam logic [12:0] COUNT_CAP = 13'((MAX_MATCHES < 8191) ? MAX_MATCHES : 8191);
  localparam logic signed [32:0] ONE = 33'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  function automatic logic [31:0] mag32(logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

  function automatic logic signed [32:0] sx28(logic [27:0] x);
    return {{5{x[27]}}, x};
  endfunction

  uword_t w;
  assign w = cmd_i.word;

  logic [27:0] coef_q [9];
  logic [23:0] fx_q, fy_q;
  logic [31:0] inv_q;
  logic [12:0] cnt_q;
  logic [31:0] score_q;

  logic              sop_q, bad_q, sat_q, zero_q;
  logic [27:0]       ax_q, ay_q, bx_q, by_q;
  logic signed [65:0] acc_q;
  logic signed [31:0] line_q [6];
  logic [WIDE_W-1:0] w_q, num_q, t_q, den_q, rem_q;
  logic [31:0]       carry_q, quo_q;
  logic [31:0]       chi_q [2];
  logic [109:0]      res_q;

  logic              load_wr;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod, acc_sh;
  logic [31:0]       factor;
  logic [63:0]       limb_t;
  logic [WIDE_W-1:0] den_sum;
  logic              rem_ge;
  logic [12:0]       base_cnt, new_cnt;
  logic [31:0]       base_score, new_score;
  logic [32:0]       bonus, ssum;
  logic              inlier;

  assign sts_o.eval_cmd = in_user_i[0];
  assign load_wr = cmd_i.accept && (in_user_i[0] == CMD_LOAD) && (in_data_i[3:0] < 4'd9);

  always_comb begin
    unique case (w.fsel)
      F_LINE:  factor = mag32(line_q[w.idx[2:0]]);
      F_INV:   factor = inv_q;
      F_FX:    factor = {8'b0, fx_q};
      F_FY:    factor = {8'b0, fy_q};
      default: factor = inv_q;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (w.op == UOP_WMUL) begin
      mul_a = {1'b0, w_q[31:0]};
      mul_b = {1'b0, factor};
    end else begin
      mul_a = (w.asrc == A_COEF) ? sx28(coef_q[w.idx]) : 33'(line_q[w.idx[2:0]]);
      unique case (w.bsel)
        B_AX:    mul_b = sx28(ax_q);
        B_AY:    mul_b = sx28(ay_q);
        B_BX:    mul_b = sx28(bx_q);
        B_BY:    mul_b = sx28(by_q);
        default: mul_b = ONE;
      endcase
    end
  end

  assign prod    = mul_a * mul_b;
  assign acc_sh  = acc_q >>> COORD_FRAC_BITS;
  assign limb_t  = prod[63:0] + {32'b0, (cmd_i.first ? 32'b0 : carry_q)};
  assign den_sum = w_q + t_q;
  assign rem_ge  = (rem_q >= den_q);

  always_comb begin
    base_cnt   = sop_q ? '0 : cnt_q;
    base_score = sop_q ? '0 : score_q;
    inlier     = !bad_q && (chi_q[0] < CHI_LIMIT) && (chi_q[1] < CHI_LIMIT);
    bonus      = {1'b0, CHI_BONUS} - {1'b0, chi_q[0]} - {1'b0, chi_q[1]};
    ssum       = {1'b0, base_score} + bonus;
    new_score  = base_score;
    new_cnt    = base_cnt;
    if (inlier) begin
      new_score = ssum[32] ? '1 : ssum[31:0];
      if (base_cnt < COUNT_CAP) begin
        new_cnt = base_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        coef_q[i] <= '0;
      end
      fx_q    <= FOCAL_RESET;
      fy_q    <= FOCAL_RESET;
      inv_q   <= INV_RESET;
      cnt_q   <= '0;
      score_q <= '0;
    end else begin
      if (load_wr) begin
        coef_q[in_data_i[3:0]] <= in_data_i[31:4];
      end
      if (cfg_we_i) begin
        priority case (cfg_index_i)
          CFG_FOCAL_X:      fx_q  <= cfg_data_i[23:0];
          CFG_FOCAL_Y:      fy_q  <= cfg_data_i[23:0];
          CFG_INV_SIGMA_SQ: inv_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (w.op == UOP_END) begin
        cnt_q   <= new_cnt;
        score_q <= new_score;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sop_q <= in_user_i[1];
      ax_q  <= in_data_i[59:32];
      ay_q  <= in_data_i[87:60];
      bx_q  <= in_data_i[115:88];
      by_q  <= in_data_i[143:116];
      bad_q <= 1'b0;
      if (in_user_i[0] == CMD_LOAD) begin
        res_q <= {32'b0, 32'b0, score_q, cnt_q, 1'b0};
      end
    end
    unique case (w.op)
      UOP_MAC_CLR: acc_q <= prod;
      UOP_MAC:     acc_q <= acc_q + prod;
      UOP_STORE: begin
        if (acc_sh > S32_MAX) begin
          line_q[w.idx[2:0]] <= S32_MAX[31:0];
        end else if (acc_sh < S32_MIN) begin
          line_q[w.idx[2:0]] <= S32_MIN[31:0];
        end else begin
          line_q[w.idx[2:0]] <= acc_sh[31:0];
        end
      end
      UOP_WSET:     w_q <= {{(WIDE_W-32){1'b0}}, mag32(line_q[w.idx[2:0]])};
      UOP_WMUL: begin
        w_q     <= {limb_t[31:0], w_q[WIDE_W-1:32]};
        carry_q <= limb_t[63:32];
      end
      UOP_SAVE_NUM: num_q <= w_q;
      UOP_SAVE_T:   t_q   <= w_q;
      UOP_DEN: begin
        den_q  <= {den_sum[WIDE_W-57:0], 56'b0};
        zero_q <= (den_sum == '0);
        rem_q  <= num_q;
        quo_q  <= '0;
      end
      UOP_SATCHK: begin
        sat_q <= zero_q || rem_ge;
        den_q <= den_q >> 1;
      end
      UOP_DIV: begin
        if (rem_ge) begin
          rem_q <= rem_q - den_q;
        end
        quo_q <= {quo_q[30:0], rem_ge};
        den_q <= den_q >> 1;
      end
      UOP_CHI: begin
        chi_q[w.idx[0]] <= sat_q ? '1 : quo_q;
        bad_q           <= bad_q | zero_q;
      end
      UOP_END:  res_q <= {chi_q[1], chi_q[0], new_score, new_cnt, inlier};
      default: ;
    endcase
  end

  assign out_data_o = res_q;

endmodule

// ===== rtl/core/epipolar_inlier_scorer.sv =====
// epipolar_inlier_scorer: top level, joins the sequencer and the datapath
// depends on eis_pkg, eis_ctrl, eis_dp
//
// usage:
//   s_axis carries one command per transaction. tuser[0] selects the kind
//   (0 load a matrix coefficient, 1 evaluate a match), tuser[1] clears the
//   inlier count and score before an evaluation. m_axis returns exactly one
//   result per command. cfg writes focal_x (0), focal_y (1), inv_sigma_sq (2)
//   and is always ready; write it only while the block is idle.
// timing:
//   a load answers on the cycle after acceptance. an evaluation runs a
//   59-step micro-program: mac steps for the lines, 18 wide multiplies
//   on one 32x32 limb multiplier and two restoring divisions. one
//   command is in flight at a time; s_axis_tready rises again in the
//   cycle after the result transaction.
// reset:
//   clears the matrix, count and score and restores the register defaults.
// stall:
//   a held result keeps m_axis_tvalid and m_axis_tdata stable and the block
//   takes no new command until the result is taken.
module epipolar_inlier_scorer import eis_pkg::*; #(
  parameter int unsigned MAX_MATCHES     = MAX_MATCHES_DEF,
  parameter int unsigned COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] coef_index, [31:4] coef_value, [59:32] point_a_x, [87:60] point_a_y,
  // [115:88] point_b_x, [143:116] point_b_y
  input  logic [143:0] s_axis_tdata,
  // [0] command, [1] start_of_pass
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] is_inlier, [13:1] inlier_total, [45:14] score_total,
  // [77:46] chi_first, [109:78] chi_second, [111:110] zero
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  dp_cmd_t      cmd;
  dp_sts_t      sts;
  logic [109:0] res;

  assign cfg_ready_o = 1'b1;

  eis_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  eis_dp #(
    .MAX_MATCHES     (MAX_MATCHES),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {2'b00, res};

endmodule

// ===== rtl/core/eis_checker.sv =====
// eis_props: port-level assertions for epipolar_inlier_scorer, bound to the top
// depends on eis_pkg
module eis_props import eis_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("new command taken while a result is pending");

  a_load_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == CMD_LOAD) |=> m_axis_tvalid)
    else $error("load transaction not answered on the next cycle");

  a_inlier_chi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      (m_axis_tdata[77:46] < CHI_LIMIT) && (m_axis_tdata[109:78] < CHI_LIMIT))
    else $error("inlier flagged with chi value over threshold");

endmodule

bind epipolar_inlier_scorer eis_props u_eis_props (.*);
